FILE: src/mp4bw_pkg.sv
package mp4bw_pkg;

    typedef logic [40:0] ofs_t;

    typedef enum logic [1:0] {
        ST_NEXT   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2,
        ST_IGNORE = 2'd3
    } status_t;

    localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
    localparam logic [31:0] TYPE_MOOV = 32'h6D6F_6F76;
    localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;

    localparam logic [31:0] SIZE_WORD_LARGE = 32'd1;
    localparam ofs_t        HDR_SMALL       = 41'd8;
    localparam ofs_t        HDR_LARGE       = 41'd16;
    localparam ofs_t        CAP_RESET       = 41'h000_4000_0000;

    typedef struct packed {
        logic        new_walk;
        logic [47:0] available_bytes;
        logic        read_failed;
        logic [31:0] size_word;
        logic [31:0] type_code;
        logic [63:0] large_size;
    } box_beat_t;

    typedef struct packed {
        ofs_t cursor;
        ofs_t limit;
        logic seen_ftyp;
        logic seen_moov;
        logic seen_mdat;
        logic walk_open;
    } walk_state_t;

    typedef struct packed {
        status_t status;
        ofs_t    offset;
    } result_t;

    // A finished walk passes only if all three box types were seen and it covered some bytes.
    function automatic result_t judge(walk_state_t s);
        result_t r;
        if (s.seen_ftyp && s.seen_moov && s.seen_mdat && (s.cursor != '0)) begin
            r.status = ST_ACCEPT;
            r.offset = s.cursor;
        end else begin
            r.status = ST_REJECT;
            r.offset = '0;
        end
        return r;
    endfunction

endpackage

FILE: src/mp4_top_box_walker.sv
// An accepted beat waits in the input register; its result is then registered in the
// output register. Throughput: one box header per cycle unless the output stalls; the
// only loop is the walk state register, updated by a single compare-and-add per beat.
// Reset (aresetn low, synchronous) empties both stages, closes any walk, clears the
// cursor, limit and flags, and loads the size cap with 2^30.
module mp4_top_box_walker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [40:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_new_walk,
    input  logic [47:0] s_available_bytes,
    input  logic        s_read_failed,
    input  logic [31:0] s_size_word,
    input  logic [31:0] s_type_code,
    input  logic [63:0] s_large_size,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [40:0] m_offset
);
    import mp4bw_pkg::*;

    box_beat_t   in_reg;
    logic        in_valid_reg;
    result_t     out_reg;
    logic        out_valid_reg;
    walk_state_t state_reg;
    walk_state_t state_next;
    result_t     result_next;
    ofs_t        cap_reg;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mp4bw_step u_step (
        .beat       (in_reg),
        .state_cur  (state_reg),
        .size_cap   (cap_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cap_reg       <= CAP_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.new_walk        <= s_new_walk;
            in_reg.available_bytes <= s_available_bytes;
            in_reg.read_failed     <= s_read_failed;
            in_reg.size_word       <= s_size_word;
            in_reg.type_code       <= s_type_code;
            in_reg.large_size      <= s_large_size;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_reg.status;
    assign m_offset = out_reg.offset;

    a_cursor_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cursor <= state_reg.limit)
        else $error("Walk cursor has passed the walk limit.");

    a_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_REJECT || m_status == ST_IGNORE) |-> m_offset == '0)
        else $error("A rejected or ignored beat carries a nonzero offset.");

    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ACCEPT |-> m_offset != '0)
        else $error("An accepted walk reports zero length.");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("Input stalled while the output register is empty.");

    a_closed_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (result_next.status == ST_ACCEPT || result_next.status == ST_REJECT)
        |=> !state_reg.walk_open)
        else $error("Walk left open after a final verdict.");

endmodule

FILE: src/mp4bw_step.sv
module mp4bw_step (
    input  mp4bw_pkg::box_beat_t   beat,
    input  mp4bw_pkg::walk_state_t state_cur,
    input  mp4bw_pkg::ofs_t        size_cap,
    output mp4bw_pkg::walk_state_t state_next,
    output mp4bw_pkg::result_t     result
);
    import mp4bw_pkg::*;

    walk_state_t st;
    ofs_t        lim_start;
    ofs_t        room;
    ofs_t        new_cursor;
    ofs_t        new_room;
    logic        hdr_large;
    logic [63:0] blk_size;
    logic [63:0] hdr_size;

    assign lim_start = (beat.available_bytes < {7'd0, size_cap})
                     ? beat.available_bytes[40:0] : size_cap;

    always_comb begin
        st = state_cur;
        if (beat.new_walk) begin
            st.cursor    = '0;
            st.limit     = lim_start;
            st.seen_ftyp = 1'b0;
            st.seen_moov = 1'b0;
            st.seen_mdat = 1'b0;
            st.walk_open = 1'b1;
        end

        // The cursor never passes the limit, so the room cannot wrap.
        room       = st.limit - st.cursor;
        hdr_large  = (beat.size_word == SIZE_WORD_LARGE);
        blk_size   = hdr_large ? beat.large_size : {32'd0, beat.size_word};
        hdr_size   = hdr_large ? {23'd0, HDR_LARGE} : {23'd0, HDR_SMALL};
        new_cursor = st.cursor + blk_size[40:0];
        new_room   = room - blk_size[40:0];

        state_next    = st;
        result.status = ST_IGNORE;
        result.offset = '0;

        if (!st.walk_open) begin
            result.status = ST_IGNORE;
        end else if (room < HDR_SMALL) begin
            state_next.walk_open = 1'b0;
            result = judge(st);
        end else if (beat.read_failed) begin
            state_next.walk_open = 1'b0;
            result.status = ST_REJECT;
        end else if (hdr_large && (room < HDR_LARGE)) begin
            state_next.walk_open = 1'b0;
            result.status = ST_REJECT;
        end else if ((blk_size < hdr_size) || (blk_size > {23'd0, room})) begin
            state_next.walk_open = 1'b0;
            result = judge(st);
        end else if ((st.cursor == '0) && (beat.type_code != TYPE_FTYP)) begin
            state_next.walk_open = 1'b0;
            result.status = ST_REJECT;
        end else begin
            state_next.cursor    = new_cursor;
            state_next.seen_ftyp = st.seen_ftyp | (beat.type_code == TYPE_FTYP);
            state_next.seen_moov = st.seen_moov | (beat.type_code == TYPE_MOOV);
            state_next.seen_mdat = st.seen_mdat | (beat.type_code == TYPE_MDAT);
            if (new_room < HDR_SMALL) begin
                state_next.walk_open = 1'b0;
                result = judge(state_next);
            end else begin
                result.status = ST_NEXT;
                result.offset = new_cursor;
            end
        end
    end

endmodule

FILE: sim/mp4_top_box_walker_test.sv
`timescale 1ns / 100ps

module mp4_top_box_walker_test;
    import mp4bw_pkg::*;

    typedef struct {
        box_beat_t beat;
        bit        typed;
        result_t   want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [40:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_new_walk = 1'b0;
    logic [47:0] s_available_bytes = '0;
    logic        s_read_failed = 1'b0;
    logic [31:0] s_size_word = '0;
    logic [31:0] s_type_code = '0;
    logic [63:0] s_large_size = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [40:0] m_offset;

    ofs_t    w_cap = CAP_RESET;
    ofs_t    w_cursor = '0;
    ofs_t    w_limit = '0;
    bit      w_ftyp = 1'b0;
    bit      w_moov = 1'b0;
    bit      w_mdat = 1'b0;
    bit      w_open = 1'b0;

    result_t pending_results[$];
    row_t    rows[$];
    int      n_sent = 0;
    int      n_results = 0;
    int      n_errors = 0;
    int      n_caps = 0;
    int      tally[4] = '{0, 0, 0, 0};
    bit      steady = 1'b0;

    mp4_top_box_walker u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_new_walk        (s_new_walk),
        .s_available_bytes (s_available_bytes),
        .s_read_failed     (s_read_failed),
        .s_size_word       (s_size_word),
        .s_type_code       (s_type_code),
        .s_large_size      (s_large_size),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_offset          (m_offset)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic result_t close_walk(bit judged);
        result_t r;
        w_open = 1'b0;
        if (judged && w_ftyp && w_moov && w_mdat && w_cursor != '0) begin
            r.status = ST_ACCEPT;
            r.offset = w_cursor;
        end else begin
            r.status = ST_REJECT;
            r.offset = '0;
        end
        return r;
    endfunction

    function automatic result_t advance_walk(box_beat_t b);
        result_t     r;
        logic [63:0] bsz;
        logic [63:0] hdr;
        r.status = ST_IGNORE;
        r.offset = '0;
        hdr = 64'd8;
        if (b.new_walk) begin
            w_cursor = '0;
            w_limit = (b.available_bytes < w_cap) ? b.available_bytes[40:0] : w_cap;
            w_ftyp = 1'b0;
            w_moov = 1'b0;
            w_mdat = 1'b0;
            w_open = 1'b1;
        end
        if (!w_open)
            return r;
        if (w_cursor + 64'd8 > w_limit)
            return close_walk(1'b1);
        if (b.read_failed)
            return close_walk(1'b0);
        bsz = {32'd0, b.size_word};
        if (b.size_word == SIZE_WORD_LARGE) begin
            if (w_cursor + 64'd16 > w_limit)
                return close_walk(1'b0);
            bsz = b.large_size;
            hdr = 64'd16;
        end
        if (bsz < hdr || bsz > w_limit - w_cursor)
            return close_walk(1'b1);
        if (w_cursor == '0 && b.type_code != TYPE_FTYP)
            return close_walk(1'b0);
        if (b.type_code == TYPE_FTYP) w_ftyp = 1'b1;
        if (b.type_code == TYPE_MOOV) w_moov = 1'b1;
        if (b.type_code == TYPE_MDAT) w_mdat = 1'b1;
        w_cursor = w_cursor + bsz[40:0];
        if (w_cursor == w_limit || w_cursor + 64'd8 > w_limit)
            return close_walk(1'b1);
        r.status = ST_NEXT;
        r.offset = w_cursor;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly well-formed walks: ftyp first, then boxes sized against the room left.
    function automatic box_beat_t next_box();
        box_beat_t   b;
        logic [63:0] room;
        logic [63:0] sz;
        int          r;
        int          k;
        r = $urandom_range(0, 99);
        b.new_walk = 1'b0;
        b.available_bytes = '0;
        b.read_failed = ($urandom_range(0, 99) < 3);
        b.size_word = $urandom;
        b.type_code = $urandom;
        b.large_size = {$urandom, $urandom};
        if (r < 8) begin
            b.new_walk = 1'($urandom_range(0, 1));
            b.available_bytes = 48'({$urandom, $urandom});
            b.read_failed = 1'($urandom_range(0, 1));
            return b;
        end
        if (!w_open || r < 12) begin
            b.new_walk = 1'b1;
            k = $urandom_range(0, 9);
            if (k < 7)
                b.available_bytes = 48'($urandom_range(0, 600));
            else if (k < 9)
                b.available_bytes = 48'($urandom_range(0, 100000));
            else
                b.available_bytes = 48'({$urandom, $urandom});
            room = 64'((b.available_bytes < w_cap) ? b.available_bytes : 48'(w_cap));
            b.type_code = ($urandom_range(0, 9) == 0) ? $urandom : TYPE_FTYP;
        end else begin
            room = {23'd0, w_limit - w_cursor};
            k = $urandom_range(0, 9);
            if (k < 3)
                b.type_code = TYPE_MOOV;
            else if (k < 6)
                b.type_code = TYPE_MDAT;
            else if (k < 7)
                b.type_code = TYPE_FTYP;
        end
        k = $urandom_range(0, 99);
        if (k < 55) begin
            sz = (room > 64'd200) ? 64'd200 : room;
            sz = (sz < 64'd8) ? 64'd8 : 64'd8 + ({$urandom, $urandom} % (sz - 64'd7));
        end else if (k < 70) begin
            sz = room;
        end else if (k < 88) begin
            sz = 64'($urandom_range(0, 7));
        end else if (k < 95) begin
            sz = room + 64'($urandom_range(1, 1000));
        end else begin
            sz = {$urandom, $urandom};
        end
        if ($urandom_range(0, 4) == 0 || sz > 64'hFFFF_FFFF) begin
            b.size_word = SIZE_WORD_LARGE;
            b.large_size = sz;
        end else begin
            b.size_word = sz[31:0];
        end
        return b;
    endfunction

    function automatic row_t mk_row(bit nw, logic [47:0] av, bit rf, logic [31:0] sw,
                                    logic [31:0] tc, logic [63:0] ls, bit typed,
                                    status_t st, ofs_t ofs);
        row_t row;
        row.beat.new_walk = nw;
        row.beat.available_bytes = av;
        row.beat.read_failed = rf;
        row.beat.size_word = sw;
        row.beat.type_code = tc;
        row.beat.large_size = ls;
        row.typed = typed;
        row.want.status = st;
        row.want.offset = ofs;
        return row;
    endfunction

    task automatic add_row(input row_t row);
        rows.insert(rows.size(), row);
    endtask

    task automatic send_box(input box_beat_t b, input bit typed, input result_t want);
        int      gap;
        result_t got;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_new_walk <= b.new_walk;
        s_available_bytes <= b.available_bytes;
        s_read_failed <= b.read_failed;
        s_size_word <= b.size_word;
        s_type_code <= b.type_code;
        s_large_size <= b.large_size;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = advance_walk(b);
        tally[got.status]++;
        pending_results.insert(pending_results.size(), typed ? want : got);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (n_results != n_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cap(input ofs_t v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        w_cap = v;
        n_caps++;
    endtask

    initial begin : sink
        int idle;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && n_sent >= 700) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                idle = pick_gap();
                if (idle > 0) begin
                    m_ready <= 1'b0;
                    repeat (idle) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result beat with nothing expected, status %0d offset %0d",
                         $time, m_status, m_offset);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                end
                if (m_offset !== want.offset) begin
                    n_errors++;
                    $display("%0t: offset expected %0d actual %0d",
                             $time, want.offset, m_offset);
                end
            end
        end
    end

    initial begin : stimulus
        ofs_t    caps[7];
        result_t none;
        none.status = ST_NEXT;
        none.offset = '0;
        caps = '{41'h100_0000_0000, 41'd0, 41'd300, 41'd8, ofs_t'($urandom_range(16, 4096)),
                 CAP_RESET, 41'h100_0000_0000};

        add_row(mk_row(0, 48'd500, 0, 32'd16, TYPE_FTYP, 64'd0, 1, ST_IGNORE, 0));
        add_row(mk_row(1, 48'd4, 0, 32'd16, TYPE_FTYP, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, '1, 0, 32'd24, '1, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, 48'd1000, 1, 32'd16, TYPE_FTYP, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, 48'd64, 0, 32'd16, TYPE_FTYP, 64'd0, 1, ST_NEXT, 41'd16));
        add_row(mk_row(0, 48'd0, 0, 32'd24, TYPE_MOOV, 64'd0, 1, ST_NEXT, 41'd40));
        add_row(mk_row(0, 48'd0, 0, 32'd24, TYPE_MDAT, 64'd0, 1, ST_ACCEPT, 41'd64));
        add_row(mk_row(0, '1, 1, '1, '1, '1, 1, ST_IGNORE, 0));
        add_row(mk_row(1, 48'd100, 0, 32'd0, TYPE_FTYP, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, '1, 0, SIZE_WORD_LARGE, TYPE_FTYP, 64'd32, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, SIZE_WORD_LARGE, TYPE_MOOV, '1, 0, ST_NEXT, 0));
        add_row(mk_row(1, 48'd12, 0, SIZE_WORD_LARGE, TYPE_FTYP, 64'd12, 1,
                       ST_REJECT, 0));
        add_row(mk_row(1, 48'd40, 0, 32'd16, TYPE_FTYP, 64'd0, 1, ST_NEXT, 41'd16));
        add_row(mk_row(0, 48'd0, 0, 32'd25, TYPE_MOOV, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, 48'd70, 0, 32'd16, TYPE_FTYP, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, 32'd20, TYPE_MDAT, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, 32'd30, TYPE_MOOV, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(1, 48'd200, 0, 32'd16, TYPE_FTYP, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, 32'd8, TYPE_MOOV, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, 32'd8, TYPE_MDAT, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(0, 48'd0, 0, 32'd7, 32'd0, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(1, 48'd1000, 0, '1, TYPE_FTYP, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(1, 48'd0, 0, 32'd16, TYPE_FTYP, 64'd0, 1, ST_REJECT, 0));
        add_row(mk_row(1, 48'd300, 0, 32'd16, TYPE_FTYP, 64'd0, 0, ST_NEXT, 0));
        add_row(mk_row(1, 48'd64, 0, 32'd8, TYPE_FTYP, 64'd0, 0, ST_NEXT, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_box(rows[i].beat, rows[i].typed, rows[i].want);
        drain();

        foreach (caps[p]) begin
            write_cap(caps[p]);
            for (int i = 0; i < 260; i++) begin
                if (i % 100 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_box(next_box(), 1'b0, none);
            end
            steady = 1'b0;
            drain();
        end
        repeat (10) @(posedge aclk);

        $display("Sent %0d box header beats across %0d size cap settings.", n_sent, n_caps);
        $display("Results: %0d next-box, %0d accepted, %0d rejected, %0d ignored.",
                 tally[ST_NEXT], tally[ST_ACCEPT], tally[ST_REJECT], tally[ST_IGNORE]);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
